[sv/bslt_pkg.sv]
package bslt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int WINDOW_BITS_DEF   = 16;
  localparam int ID_BITS_DEF       = 48;

  localparam int EPOCH_W = 16;
  localparam int SEQ_W   = 32;
  localparam int RETRY_W = 4;
  localparam int LIMIT_W = 3;

  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RESET = 3'd5;

  localparam logic CMD_RECV = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // subtractor result: a - b modulo 2^32, borrow set when a < b
  typedef struct packed {
    logic [SEQ_W-1:0] diff;
    logic             borrow;
  } alu_res_t;

endpackage

[sv/bslt_mem.sv]
module bslt_mem #(
  parameter int DEPTH = bslt_pkg::TABLE_ENTRIES_DEF,
  parameter int AW    = 4,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/bslt_alu.sv]
module bslt_alu (
  input  logic [bslt_pkg::SEQ_W-1:0] a,
  input  logic [bslt_pkg::SEQ_W-1:0] b,
  output bslt_pkg::alu_res_t         res
);

  logic [bslt_pkg::SEQ_W:0] full;

  // one shared 32-bit subtractor, borrow doubles as unsigned a < b
  assign full       = {1'b0, a} - {1'b0, b};
  assign res.diff   = full[bslt_pkg::SEQ_W-1:0];
  assign res.borrow = full[bslt_pkg::SEQ_W];

endmodule

[sv/broadcast_sequence_loss_tracker.sv]
// Broadcast sequence loss tracker. Follows up to TABLE_ENTRIES senders, each
// with a WINDOW_BITS-wide bitmap of received sequences (bit k = latest - k).
// Issue an item with start while busy is low; busy stays high until the one
// result for that item appears on the out_ ports for a single cycle, marked by
// out_strobe. The receiver cannot stall: a result must be taken in the cycle
// it is shown, and a new item may be started in that same cycle.
// Every receive walks the whole entry table through the single read port of
// the entry RAM, one entry per cycle, then for a known sender compares the
// sequence with the latest (a repeat of the latest ends there; an older one
// takes a second subtraction) and writes back the bitmap. A tick walks the
// table only up to the first valid entry with a missing bit, then finds its
// lowest missing bit one bit per cycle and writes back the entry.
// No clearing pass is needed after reset: entry valid bits live in flops.
// cfg_ready is always high; write retry_limit only while the block is idle.
module broadcast_sequence_loss_tracker #(
  parameter int TABLE_ENTRIES = bslt_pkg::TABLE_ENTRIES_DEF,
  parameter int WINDOW_BITS   = bslt_pkg::WINDOW_BITS_DEF,
  parameter int ID_BITS       = bslt_pkg::ID_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic [ID_BITS-1:0]                in_source_id,
  input  logic [bslt_pkg::EPOCH_W-1:0]      in_epoch,
  input  logic [bslt_pkg::SEQ_W-1:0]        in_seq_number,
  // result channel
  output logic                              out_strobe,
  output logic                              out_request_valid,
  output logic [ID_BITS-1:0]                out_request_source,
  output logic [bslt_pkg::EPOCH_W-1:0]      out_request_epoch,
  output logic [bslt_pkg::SEQ_W-1:0]        out_request_sequence,
  output logic                              out_table_full,
  // retry_limit write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bslt_pkg::LIMIT_W-1:0]      cfg_data
);

  localparam int EPOCH_W = bslt_pkg::EPOCH_W;
  localparam int SEQ_W   = bslt_pkg::SEQ_W;
  localparam int RETRY_W = bslt_pkg::RETRY_W;
  localparam int LIMIT_W = bslt_pkg::LIMIT_W;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = $clog2(WINDOW_BITS);

  // entry word layout, LSB first: retries, bitmap, latest seq, epoch, source
  localparam int O_BITS = RETRY_W;
  localparam int O_SEQ  = O_BITS + WINDOW_BITS;
  localparam int O_EP   = O_SEQ + SEQ_W;
  localparam int O_SRC  = O_EP + EPOCH_W;
  localparam int DW     = O_SRC + ID_BITS;

  localparam logic [CW-1:0]          END_CNT  = CW'(TABLE_ENTRIES);
  localparam logic [WINDOW_BITS-1:0] WIN_ONES = '1;
  localparam logic [WINDOW_BITS-1:0] WIN_ONE  = WINDOW_BITS'(1);
  localparam logic [SEQ_W-1:0]       WIN_LEN  = SEQ_W'(WINDOW_BITS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,   // walk the table
    S_DIFF = 7'b0000100,   // seq - latest
    S_NEG  = 7'b0001000,   // latest - seq, older packet
    S_UPD  = 7'b0010000,   // bitmap update and write back
    S_FIND = 7'b0100000,   // lowest missing bit, one bit per cycle
    S_TUPD = 7'b1000000    // request and retry bookkeeping
  } state_t;

  state_t state_r, state_nxt;

  // control
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic                     ev_ok_r, ev_ok_nxt;
  logic [AW-1:0]            ev_idx_r, ev_idx_nxt;
  logic                     hit_r, hit_nxt;
  logic [AW-1:0]            hit_idx_r, hit_idx_nxt;
  logic                     free_r, free_nxt;
  logic [AW-1:0]            free_idx_r, free_idx_nxt;
  logic [LIMIT_W-1:0]       limit_r;
  logic                     out_strobe_r;

  // item and captured entry
  logic                     cmd_r, cmd_nxt;
  logic [ID_BITS-1:0]       src_r, src_nxt;
  logic [EPOCH_W-1:0]       ep_r, ep_nxt;
  logic [SEQ_W-1:0]         seq_r, seq_nxt;
  logic [ID_BITS-1:0]       cap_src_r, cap_src_nxt;
  logic [EPOCH_W-1:0]       cap_ep_r, cap_ep_nxt;
  logic [SEQ_W-1:0]         cap_seq_r, cap_seq_nxt;
  logic [WINDOW_BITS-1:0]   cap_bits_r, cap_bits_nxt;
  logic [RETRY_W-1:0]       cap_ret_r, cap_ret_nxt;
  logic [SEQ_W-1:0]         d_r, d_nxt;
  logic                     newer_r, newer_nxt;
  logic [SW-1:0]            k_r, k_nxt;

  // result registers
  logic                     res_valid_r;
  logic [ID_BITS-1:0]       res_src_r;
  logic [EPOCH_W-1:0]       res_ep_r;
  logic [SEQ_W-1:0]         res_seq_r;
  logic                     res_full_r;

  // per-cycle result
  logic                     emit;
  logic                     res_valid;
  logic [ID_BITS-1:0]       res_src;
  logic [EPOCH_W-1:0]       res_ep;
  logic [SEQ_W-1:0]         res_seq;
  logic                     res_full;

  // RAM ports
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [DW-1:0]            mem_wdata;
  logic [DW-1:0]            mem_rdata;

  // shared subtractor
  logic [SEQ_W-1:0]         alu_a, alu_b;
  bslt_pkg::alu_res_t       alu_res;

  // entry under evaluation
  logic [ID_BITS-1:0]       rd_src;
  logic [EPOCH_W-1:0]       rd_ep;
  logic [SEQ_W-1:0]         rd_seq;
  logic [WINDOW_BITS-1:0]   rd_bits;
  logic [RETRY_W-1:0]       rd_ret;
  logic                     rd_valid;
  logic                     src_eq, ep_eq;

  // update helpers
  logic                     in_win;
  logic [SW-1:0]            shamt;
  logic [WINDOW_BITS-1:0]   upd_bits;
  logic [RETRY_W-1:0]       ret_inc;
  logic                     give_up;

  bslt_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  bslt_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign rd_src   = mem_rdata[O_SRC +: ID_BITS];
  assign rd_ep    = mem_rdata[O_EP +: EPOCH_W];
  assign rd_seq   = mem_rdata[O_SEQ +: SEQ_W];
  assign rd_bits  = mem_rdata[O_BITS +: WINDOW_BITS];
  assign rd_ret   = mem_rdata[0 +: RETRY_W];
  assign rd_valid = valid_r[ev_idx_r];
  assign src_eq   = (rd_src == src_r);
  assign ep_eq    = (rd_ep == ep_r);

  assign in_win  = (d_r < WIN_LEN);
  assign shamt   = d_r[SW-1:0];
  assign ret_inc = cap_ret_r + RETRY_W'(1);
  assign give_up = (ret_inc > RETRY_W'(limit_r));

  // bitmap update for a known sender
  always_comb begin
    if (newer_r) begin
      upd_bits = in_win ? ((cap_bits_r << shamt) | WIN_ONE) : WIN_ONE;
    end else begin
      upd_bits = in_win ? (cap_bits_r | (WIN_ONE << shamt)) : cap_bits_r;
    end
  end

  // subtractor operands by step
  always_comb begin
    alu_a = seq_r;
    alu_b = cap_seq_r;
    case (state_r)
      S_NEG: begin
        alu_a = cap_seq_r;
        alu_b = seq_r;
      end
      S_TUPD: begin
        alu_a = cap_seq_r;
        alu_b = SEQ_W'(k_r);
      end
      default: begin
        alu_a = seq_r;
        alu_b = cap_seq_r;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    idx_nxt      = idx_r;
    ev_ok_nxt    = ev_ok_r;
    ev_idx_nxt   = ev_idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    cmd_nxt      = cmd_r;
    src_nxt      = src_r;
    ep_nxt       = ep_r;
    seq_nxt      = seq_r;
    cap_src_nxt  = cap_src_r;
    cap_ep_nxt   = cap_ep_r;
    cap_seq_nxt  = cap_seq_r;
    cap_bits_nxt = cap_bits_r;
    cap_ret_nxt  = cap_ret_r;
    d_nxt        = d_r;
    newer_nxt    = newer_r;
    k_nxt        = k_r;

    mem_we    = 1'b0;
    mem_waddr = hit_idx_r;
    mem_wdata = {src_r, ep_r, seq_r, WIN_ONES, RETRY_W'(0)};

    emit      = 1'b0;
    res_valid = 1'b0;
    res_src   = '0;
    res_ep    = '0;
    res_seq   = '0;
    res_full  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_cmd;
          src_nxt   = in_source_id;
          ep_nxt    = in_epoch;
          seq_nxt   = in_seq_number;
          idx_nxt   = '0;
          ev_ok_nxt = 1'b0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // read entry idx while judging the one read last cycle
        if (idx_r != END_CNT) begin
          idx_nxt    = idx_r + CW'(1);
          ev_ok_nxt  = 1'b1;
          ev_idx_nxt = idx_r[AW-1:0];
        end else begin
          ev_ok_nxt = 1'b0;
        end

        if (ev_ok_r) begin
          if (cmd_r == bslt_pkg::CMD_RECV) begin
            // same sender, new epoch: drop it, slot becomes free
            if (rd_valid && src_eq && !ep_eq) begin
              valid_nxt[ev_idx_r] = 1'b0;
              if (!free_r) begin
                free_nxt     = 1'b1;
                free_idx_nxt = ev_idx_r;
              end
            end else if (!rd_valid && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = ev_idx_r;
            end
            if (rd_valid && src_eq && ep_eq && !hit_r) begin
              hit_nxt      = 1'b1;
              hit_idx_nxt  = ev_idx_r;
              cap_seq_nxt  = rd_seq;
              cap_bits_nxt = rd_bits;
              cap_ret_nxt  = rd_ret;
            end
          end else if (rd_valid && (rd_bits != WIN_ONES)) begin
            // first entry with a gap
            hit_idx_nxt  = ev_idx_r;
            cap_src_nxt  = rd_src;
            cap_ep_nxt   = rd_ep;
            cap_seq_nxt  = rd_seq;
            cap_bits_nxt = rd_bits;
            cap_ret_nxt  = rd_ret;
            k_nxt        = '0;
            state_nxt    = S_FIND;
          end
        end else if (idx_r == END_CNT) begin
          if (cmd_r == bslt_pkg::CMD_RECV) begin
            if (hit_r) begin
              state_nxt = S_DIFF;
            end else begin
              // new sender
              emit      = 1'b1;
              res_full  = !free_r;
              state_nxt = S_IDLE;
              if (free_r) begin
                mem_we                = 1'b1;
                mem_waddr             = free_idx_r;
                valid_nxt[free_idx_r] = 1'b1;
              end
            end
          end else begin
            // tick with nothing missing
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      S_DIFF: begin
        if (alu_res.borrow) begin
          state_nxt = S_NEG;
        end else if (alu_res.diff == '0) begin
          // duplicate of latest
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          d_nxt     = alu_res.diff;
          newer_nxt = 1'b1;
          state_nxt = S_UPD;
        end
      end

      S_NEG: begin
        d_nxt     = alu_res.diff;
        newer_nxt = 1'b0;
        state_nxt = S_UPD;
      end

      S_UPD: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx_r;
        mem_wdata = {src_r, ep_r, (newer_r ? seq_r : cap_seq_r), upd_bits, cap_ret_r};
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      S_FIND: begin
        if (!cap_bits_r[k_r]) begin
          state_nxt = S_TUPD;
        end else begin
          k_nxt = k_r + SW'(1);
        end
      end

      S_TUPD: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx_r;
        mem_wdata = {cap_src_r, cap_ep_r, cap_seq_r,
                     (give_up ? (cap_bits_r | (WIN_ONE << k_r)) : cap_bits_r),
                     (give_up ? RETRY_W'(0) : ret_inc)};
        emit      = 1'b1;
        res_valid = 1'b1;
        res_src   = cap_src_r;
        res_ep    = cap_ep_r;
        res_seq   = alu_res.diff;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      idx_r        <= '0;
      ev_ok_r      <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      limit_r      <= bslt_pkg::RETRY_LIMIT_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      idx_r        <= idx_nxt;
      ev_ok_r      <= ev_ok_nxt;
      hit_r        <= hit_nxt;
      free_r       <= free_nxt;
      out_strobe_r <= emit;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ev_idx_r   <= ev_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    cmd_r      <= cmd_nxt;
    src_r      <= src_nxt;
    ep_r       <= ep_nxt;
    seq_r      <= seq_nxt;
    cap_src_r  <= cap_src_nxt;
    cap_ep_r   <= cap_ep_nxt;
    cap_seq_r  <= cap_seq_nxt;
    cap_bits_r <= cap_bits_nxt;
    cap_ret_r  <= cap_ret_nxt;
    d_r        <= d_nxt;
    newer_r    <= newer_nxt;
    k_r        <= k_nxt;
    if (emit) begin
      res_valid_r <= res_valid;
      res_src_r   <= res_src;
      res_ep_r    <= res_ep;
      res_seq_r   <= res_seq;
      res_full_r  <= res_full;
    end
  end

  assign busy                 = (state_r != S_IDLE);
  assign cfg_ready            = 1'b1;
  assign out_strobe           = out_strobe_r;
  assign out_request_valid    = res_valid_r;
  assign out_request_source   = res_src_r;
  assign out_request_epoch    = res_ep_r;
  assign out_request_sequence = res_seq_r;
  assign out_table_full       = res_full_r;

endmodule
